>>> hw/rtl/kmp_pkg.sv
// kmp_pkg: shared types and constants for the kmp stream matcher
// opcodes, sequencer states and the control/status structs between the fsm and the datapath
// no dependencies

package kmp_pkg;

    localparam int PATTERN_DEPTH = 64;
    localparam int POSITION_BITS = 24;
    localparam int OPCODE_BITS   = 2;
    localparam int BYTE_BITS     = 8;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_CLEAR   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_RESTART = 2'd2,
        OP_TEXT    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CMP,
        ST_DONE
    } t_state;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic    in_valid;
        t_opcode in_op;
        logic    len_zero;
        logic    len_full;
        logic    hit;
        logic    k_zero;
        logic    out_busy;
    } t_status;

    // sequencer commands to the datapath
    typedef struct packed {
        logic in_ready;
        logic step_adv;
        logic step_fall;
        logic finish;
    } t_ctrl;

endpackage

>>> hw/rtl/kmp_ram.sv
// kmp_ram: generic single write port, single read port ram with registered read
// used for the pattern store and the border table
// no dependencies

module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/kmp_fsm.sv
// kmp_fsm: sequencer that drives the shared compare step of the matcher
// one fetch/compare pair, plus one per failure link, then the done state
// depends on kmp_pkg

module kmp_fsm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  kmp_pkg::t_status i_status,
    output kmp_pkg::t_ctrl   o_ctrl
);

    kmp_pkg::t_state r_state;
    kmp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kmp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_ctrl           = '0;
        unique case (r_state)
            kmp_pkg::ST_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                if (i_status.in_valid) begin
                    unique case (i_status.in_op)
                        kmp_pkg::OP_CLEAR,
                        kmp_pkg::OP_RESTART: n_state = kmp_pkg::ST_DONE;
                        kmp_pkg::OP_APPEND: begin
                            n_state = (i_status.len_full || i_status.len_zero) ?
                                      kmp_pkg::ST_DONE : kmp_pkg::ST_FETCH;
                        end
                        kmp_pkg::OP_TEXT: begin
                            n_state = i_status.len_zero ? kmp_pkg::ST_DONE
                                                        : kmp_pkg::ST_FETCH;
                        end
                        default: n_state = kmp_pkg::ST_DONE;
                    endcase
                end
            end
            kmp_pkg::ST_FETCH: begin
                n_state = kmp_pkg::ST_CMP;
            end
            kmp_pkg::ST_CMP: begin
                priority if (i_status.hit) begin
                    o_ctrl.step_adv = 1'b1;
                    n_state         = kmp_pkg::ST_DONE;
                end else if (i_status.k_zero) begin
                    n_state = kmp_pkg::ST_DONE;
                end else begin
                    o_ctrl.step_fall = 1'b1;
                    n_state          = kmp_pkg::ST_FETCH;
                end
            end
            kmp_pkg::ST_DONE: begin
                if (!i_status.out_busy) begin
                    o_ctrl.finish = 1'b1;
                    n_state       = kmp_pkg::ST_IDLE;
                end
            end
            default: n_state = kmp_pkg::ST_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/kmp_stream_matcher.sv
// kmp_stream_matcher: knuth-morris-pratt matcher over a byte stream, top level
// datapath registers, pattern and border rams, output register; uses kmp_fsm, kmp_ram, kmp_pkg
//
// channel  dir  tdata (low bit up)                              tuser
// s_axis   in   data_byte[7:0]                                  opcode[1:0]
// m_axis   out  match_found, match_start, match_total,          -
//               error_flag, zero pad to whole bytes
//
// clear, restart, full append and anything with an empty pattern: idle, then done
// append and text byte: a fetch/compare pair, one more per failure link followed, then done;
// each compare step waits on one registered ram read
// one item at a time; s_axis_tready is high only while the sequencer is idle
// a finished result waits in the output register while the next item is taken
// reset is synchronous, active low, and returns to an empty pattern

module kmp_stream_matcher #(
    parameter int PATTERN_DEPTH = kmp_pkg::PATTERN_DEPTH,
    parameter int POSITION_BITS = kmp_pkg::POSITION_BITS,
    localparam int OUT_W = ((2 * POSITION_BITS + 2 + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [kmp_pkg::BYTE_BITS-1:0]   s_axis_tdata,   // data_byte
    input  logic [kmp_pkg::OPCODE_BITS-1:0] s_axis_tuser,   // opcode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [OUT_W-1:0]                m_axis_tdata    // found, start, total, error
);

    localparam int IDX_W = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int LEN_W = $clog2(PATTERN_DEPTH + 1);
    localparam int CMP_W = (POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    kmp_pkg::t_status w_status;
    kmp_pkg::t_ctrl   w_ctrl;

    kmp_pkg::t_opcode               r_op;
    logic [kmp_pkg::BYTE_BITS-1:0]  r_c;
    logic [LEN_W-1:0]               r_k;
    logic [LEN_W-1:0]               r_len;
    logic [LEN_W-1:0]               r_bbi;
    logic [LEN_W-1:0]               r_matched;
    logic [POSITION_BITS-1:0]       r_pos;
    logic [POSITION_BITS-1:0]       r_occ;
    logic                           r_out_valid;
    logic [OUT_W-1:0]               r_out_data;

    logic [LEN_W-1:0]               n_len;
    logic [LEN_W-1:0]               n_bbi;
    logic [LEN_W-1:0]               n_matched;
    logic [POSITION_BITS-1:0]       n_pos;
    logic [POSITION_BITS-1:0]       n_occ;
    logic [OUT_W-1:0]               n_out_data;

    logic [kmp_pkg::BYTE_BITS-1:0]  w_pat_rd;
    logic [IDX_W-1:0]               w_brd_rd;
    logic [LEN_W-1:0]               w_k_dec;
    logic                           w_in_acc;
    logic                           w_we;
    logic                           w_found;
    logic                           w_err;
    logic [POSITION_BITS-1:0]       w_start;
    logic [CMP_W-1:0]               w_pos_ext;
    logic [CMP_W-1:0]               w_k_ext;

    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_k_dec  = r_k - LEN_W'(1);

    assign w_status.in_valid = s_axis_tvalid;
    assign w_status.in_op    = kmp_pkg::t_opcode'(s_axis_tuser);
    assign w_status.len_zero = (r_len == '0);
    assign w_status.len_full = (r_len == LEN_W'(PATTERN_DEPTH));
    assign w_status.hit      = (r_k < r_len) && (w_pat_rd == r_c);
    assign w_status.k_zero   = (r_k == '0);
    assign w_status.out_busy = r_out_valid && !m_axis_tready;

    kmp_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    assign w_we = w_ctrl.finish && (r_op == kmp_pkg::OP_APPEND) && !w_status.len_full;

    kmp_ram #(
        .WIDTH (kmp_pkg::BYTE_BITS),
        .DEPTH (PATTERN_DEPTH)
    ) u_pattern_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_len[IDX_W-1:0]),
        .i_wdata (r_c),
        .i_raddr (r_k[IDX_W-1:0]),
        .o_rdata (w_pat_rd)
    );

    kmp_ram #(
        .WIDTH (IDX_W),
        .DEPTH (PATTERN_DEPTH)
    ) u_border_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_len[IDX_W-1:0]),
        .i_wdata (r_k[IDX_W-1:0]),
        .i_raddr (w_k_dec[IDX_W-1:0]),
        .o_rdata (w_brd_rd)
    );

    // finish-cycle update of the scan and pattern state, and the result word
    always_comb begin
        n_len      = r_len;
        n_bbi      = r_bbi;
        n_matched  = r_matched;
        n_pos      = r_pos;
        n_occ      = r_occ;
        w_found    = 1'b0;
        w_err      = 1'b0;
        w_start    = '0;
        w_pos_ext  = '0;
        w_k_ext    = CMP_W'(r_k);
        n_out_data = '0;
        unique case (r_op)
            kmp_pkg::OP_CLEAR: begin
                n_len     = '0;
                n_bbi     = '0;
                n_matched = '0;
                n_pos     = '0;
                n_occ     = '0;
            end
            kmp_pkg::OP_RESTART: begin
                n_matched = '0;
                n_pos     = '0;
                n_occ     = '0;
            end
            kmp_pkg::OP_APPEND: begin
                if (w_status.len_full) begin
                    w_err = 1'b1;
                end else begin
                    n_bbi = r_k;
                    n_len = r_len + LEN_W'(1);
                end
            end
            kmp_pkg::OP_TEXT: begin
                if (r_pos == POS_MAX) begin
                    w_err = 1'b1;
                end else begin
                    n_pos = r_pos + POSITION_BITS'(1);
                end
                w_pos_ext = CMP_W'(n_pos);
                n_matched = r_k;
                if (!w_status.len_zero && (r_k == r_len)) begin
                    w_found = 1'b1;
                    if (w_pos_ext >= w_k_ext) begin
                        w_start = POSITION_BITS'(w_pos_ext - w_k_ext);
                    end
                    if (r_occ == POS_MAX) begin
                        w_err = 1'b1;
                    end else begin
                        n_occ = r_occ + POSITION_BITS'(1);
                    end
                    n_matched = r_bbi;
                end
            end
            default: begin
                n_len = r_len;
            end
        endcase
        n_out_data[0]                                 = w_found;
        n_out_data[POSITION_BITS:1]                   = w_start;
        n_out_data[2*POSITION_BITS:POSITION_BITS+1]   = n_occ;
        n_out_data[2*POSITION_BITS+1]                 = w_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_bbi       <= '0;
            r_matched   <= '0;
            r_pos       <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ctrl.finish) begin
                r_len       <= n_len;
                r_bbi       <= n_bbi;
                r_matched   <= n_matched;
                r_pos       <= n_pos;
                r_occ       <= n_occ;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op <= kmp_pkg::t_opcode'(s_axis_tuser);
            r_c  <= s_axis_tdata;
            r_k  <= (kmp_pkg::t_opcode'(s_axis_tuser) == kmp_pkg::OP_TEXT) ? r_matched : r_bbi;
        end else if (w_ctrl.step_adv) begin
            r_k <= r_k + LEN_W'(1);
        end else if (w_ctrl.step_fall) begin
            r_k <= LEN_W'(w_brd_rd);
        end
        if (w_ctrl.finish) begin
            r_out_data <= n_out_data;
        end
    end

    assign s_axis_tready = w_ctrl.in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> hw/rtl/kmp_checker.sv
// kmp_checker: port-level checks for kmp_stream_matcher, bound to the top level
// depends on kmp_pkg and kmp_stream_matcher

module kmp_checker #(
    parameter int POSITION_BITS = kmp_pkg::POSITION_BITS,
    localparam int OUT_W = ((2 * POSITION_BITS + 2 + 7) / 8) * 8
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [OUT_W-1:0]                m_axis_tdata
);

    localparam int ST_LO = 1;
    localparam int ST_HI = POSITION_BITS;
    localparam int TO_LO = POSITION_BITS + 1;
    localparam int TO_HI = 2 * POSITION_BITS;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken while another is in work");

    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[ST_HI:ST_LO] == '0)
        else $error("match start set without a match");

    a_total_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[TO_HI:TO_LO] != '0)
        else $error("match reported with a zero total");

endmodule

bind kmp_stream_matcher kmp_checker #(
    .POSITION_BITS (POSITION_BITS)
) u_kmp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> test/kmp_stream_matcher_test.sv
// kmp_stream_matcher_test: self-checking bench for the kmp stream matcher
// drives pattern, restart, clear and text items with random stalls and checks every result
// against an in-bench kmp model; depends on kmp_pkg and kmp_stream_matcher

module kmp_stream_matcher_test;

    localparam int OUT_W       = ((2 * kmp_pkg::POSITION_BITS + 2 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int CALM_TAIL   = 100;
    localparam logic [kmp_pkg::POSITION_BITS-1:0] POS_MAX = {kmp_pkg::POSITION_BITS{1'b1}};

    typedef struct {
        kmp_pkg::t_opcode op;
        logic [7:0]       data;
    } t_cmd;

    typedef struct {
        logic                              found;
        logic [kmp_pkg::POSITION_BITS-1:0] start;
        logic [kmp_pkg::POSITION_BITS-1:0] total;
        logic                              err;
    } t_match_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [kmp_pkg::BYTE_BITS-1:0]   s_axis_tdata = '0;     // data_byte
    logic [kmp_pkg::OPCODE_BITS-1:0] s_axis_tuser = '0;     // opcode
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [OUT_W-1:0]                m_axis_tdata;          // found, start, total, error, pad

    kmp_stream_matcher DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    t_cmd          pending_items[$];
    t_match_result expected_results[$];

    // model state of the matcher
    logic [7:0]                        pat_mem    [kmp_pkg::PATTERN_DEPTH];
    logic [5:0]                        border_mem [kmp_pkg::PATTERN_DEPTH];
    logic [6:0]                        pat_len         = '0;
    logic [6:0]                        whole_border    = '0;
    logic                              whole_border_ok = 1'b0;
    logic [6:0]                        partial_len     = '0;
    logic [kmp_pkg::POSITION_BITS-1:0] scan_pos        = '0;
    logic [kmp_pkg::POSITION_BITS-1:0] hit_count       = '0;

    int total_items = 0;
    int in_accepted = 0;
    int out_checked = 0;
    int mismatches  = 0;
    int cycle_count = 0;
    int n_text      = 0;
    int n_hits      = 0;
    int n_full      = 0;

    task automatic reset_model();
        pat_len         = '0;
        whole_border    = '0;
        whole_border_ok = 1'b0;
        partial_len     = '0;
        scan_pos        = '0;
        hit_count       = '0;
    endtask

    task automatic predict_matcher(input kmp_pkg::t_opcode op, input logic [7:0] c);
        t_match_result r;
        logic [6:0]    k;
        logic [6:0]    b;
        logic          done;
        r = '{found: 1'b0, start: '0, total: '0, err: 1'b0};
        case (op)
            kmp_pkg::OP_CLEAR: begin
                reset_model();
            end
            kmp_pkg::OP_RESTART: begin
                partial_len = '0;
                scan_pos    = '0;
                hit_count   = '0;
            end
            kmp_pkg::OP_APPEND: begin
                if (pat_len >= kmp_pkg::PATTERN_DEPTH) begin
                    r.err = 1'b1;
                    n_full++;
                end else begin
                    pat_mem[pat_len] = c;
                    b = '0;
                    if (whole_border_ok && pat_len > 0) begin
                        k = whole_border;
                        while (k > 0 && pat_mem[k] != c)
                            k = border_mem[k - 1];
                        b = (pat_mem[k] == c) ? k + 7'd1 : 7'd0;
                    end
                    border_mem[pat_len] = b[5:0];
                    whole_border        = b;
                    whole_border_ok     = 1'b1;
                    pat_len             = pat_len + 7'd1;
                end
            end
            default: begin
                n_text++;
                k    = partial_len;
                done = 1'b0;
                while (!done) begin
                    if (k < pat_len && pat_mem[k] == c) begin
                        k    = k + 7'd1;
                        done = 1'b1;
                    end else if (k == 0) begin
                        done = 1'b1;
                    end else begin
                        k = border_mem[k - 1];
                    end
                end
                if (scan_pos == POS_MAX)
                    r.err = 1'b1;
                else
                    scan_pos = scan_pos + 1'b1;
                if (pat_len > 0 && k == pat_len) begin
                    n_hits++;
                    r.found = 1'b1;
                    r.start = (scan_pos >= k) ? scan_pos - k : '0;
                    if (hit_count == POS_MAX)
                        r.err = 1'b1;
                    else
                        hit_count = hit_count + 1'b1;
                    k = border_mem[k - 1];
                end
                partial_len = k;
            end
        endcase
        r.total = hit_count;
        expected_results.push_back(r);
    endtask

    task automatic push_item(input kmp_pkg::t_opcode op, input logic [7:0] data);
        t_cmd cmd;
        cmd.op   = op;
        cmd.data = data;
        pending_items.push_back(cmd);
    endtask

    function automatic logic [7:0] pick_symbol(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] x);
        int r;
        r = $urandom_range(0, 19);
        if (r < 9)
            return a;
        else if (r < 17)
            return b;
        else if (r < 19)
            return x;
        return 8'($urandom);
    endfunction

    // without a clear, appends keep piling up; clear now and then so most sessions stay short
    function automatic logic pat_len_hint(input int queued);
        return (queued % 5) == 0;
    endfunction

    // stimulus driver
    int   in_gap = 0;
    int   in_seg_left = 0;
    logic in_seg_calm = 1'b0;

    always @(posedge i_clk) begin
        t_cmd cmd;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_matcher(kmp_pkg::t_opcode'(s_axis_tuser), s_axis_tdata);
                in_accepted++;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    if (in_seg_left == 0) begin
                        in_seg_left = $urandom_range(10, 60);
                        in_seg_calm = ($urandom_range(0, 2) == 0);
                    end else begin
                        in_seg_left--;
                    end
                    if (!in_seg_calm && in_accepted + CALM_TAIL < total_items &&
                        $urandom_range(0, 3) == 0) begin
                        in_gap = $urandom_range(0, 5);
                        s_axis_tvalid <= 1'b0;
                    end else begin
                        cmd = pending_items.pop_front();
                        s_axis_tvalid <= 1'b1;
                        s_axis_tdata  <= cmd.data;
                        s_axis_tuser  <= cmd.op;
                    end
                end
            end
        end
    end

    // result monitor
    int   out_gap = 0;
    int   out_seg_left = 0;
    logic out_seg_calm = 1'b0;

    always @(posedge i_clk) begin
        t_match_result exp_r;
        t_match_result got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.found = m_axis_tdata[0];
                got.start = m_axis_tdata[kmp_pkg::POSITION_BITS:1];
                got.total = m_axis_tdata[2*kmp_pkg::POSITION_BITS:kmp_pkg::POSITION_BITS+1];
                got.err   = m_axis_tdata[2*kmp_pkg::POSITION_BITS+1];
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: found=%0b start=%0d total=%0d err=%0b",
                                 got.found, got.start, got.total, got.err);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.found !== exp_r.found || got.start !== exp_r.start ||
                        got.total !== exp_r.total || got.err !== exp_r.err) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d: expected found=%0b start=%0d total=%0d ",
                                      "err=%0b, got found=%0b start=%0d total=%0d err=%0b"},
                                     out_checked, exp_r.found, exp_r.start, exp_r.total,
                                     exp_r.err, got.found, got.start, got.total, got.err);
                    end
                end
                out_checked++;
            end
            if (out_gap > 0) begin
                out_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                if (out_seg_left == 0) begin
                    out_seg_left = $urandom_range(10, 60);
                    out_seg_calm = ($urandom_range(0, 2) == 0);
                end else begin
                    out_seg_left--;
                end
                if (!out_seg_calm && out_checked + CALM_TAIL < total_items &&
                    $urandom_range(0, 3) == 0) begin
                    out_gap = $urandom_range(0, 5);
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, expected_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int         kind;
        int         plen;
        int         tlen;
        int         fills;
        logic [7:0] sym_a;
        logic [7:0] sym_b;
        logic [7:0] sym_x;
        fills = 0;

        // empty pattern never matches
        push_item(kmp_pkg::OP_TEXT, 8'h00);
        push_item(kmp_pkg::OP_TEXT, 8'hFF);
        // overlapping matches of a repeated byte
        push_item(kmp_pkg::OP_APPEND, 8'hFF);
        push_item(kmp_pkg::OP_APPEND, 8'hFF);
        push_item(kmp_pkg::OP_TEXT, 8'hFF);
        push_item(kmp_pkg::OP_TEXT, 8'hFF);
        push_item(kmp_pkg::OP_TEXT, 8'hFF);
        push_item(kmp_pkg::OP_TEXT, 8'h00);
        // append in the middle of a scan
        push_item(kmp_pkg::OP_TEXT, 8'hFF);
        push_item(kmp_pkg::OP_APPEND, 8'h00);
        push_item(kmp_pkg::OP_TEXT, 8'hFF);
        push_item(kmp_pkg::OP_TEXT, 8'h00);
        // restart keeps the pattern, data is ignored
        push_item(kmp_pkg::OP_RESTART, 8'hA5);
        push_item(kmp_pkg::OP_TEXT, 8'hFF);
        push_item(kmp_pkg::OP_TEXT, 8'hFF);
        push_item(kmp_pkg::OP_TEXT, 8'h00);
        push_item(kmp_pkg::OP_TEXT, 8'h00);
        // clear drops the pattern, data is ignored
        push_item(kmp_pkg::OP_CLEAR, 8'h5A);
        push_item(kmp_pkg::OP_TEXT, 8'hFF);
        push_item(kmp_pkg::OP_APPEND, 8'h00);
        push_item(kmp_pkg::OP_TEXT, 8'h00);
        push_item(kmp_pkg::OP_TEXT, 8'h00);

        while (pending_items.size() < 950) begin
            kind  = (fills == 0) ? 1 : $urandom_range(0, 9);
            sym_a = 8'($urandom);
            sym_b = 8'($urandom);
            sym_x = 8'($urandom);
            if (kind == 0) begin
                repeat ($urandom_range(1, 8))
                    push_item(kmp_pkg::t_opcode'($urandom_range(0, 3)), 8'($urandom));
            end else if (kind == 1 && fills < 2) begin
                // fill the store past capacity, then scan a long run
                fills++;
                push_item(kmp_pkg::OP_CLEAR, 8'($urandom));
                repeat (kmp_pkg::PATTERN_DEPTH + $urandom_range(1, 3))
                    push_item(kmp_pkg::OP_APPEND, sym_a);
                push_item(kmp_pkg::OP_RESTART, 8'($urandom));
                repeat ($urandom_range(60, 72))
                    push_item(kmp_pkg::OP_TEXT,
                              ($urandom_range(0, 30) == 0) ? sym_b : sym_a);
            end else begin
                if ($urandom_range(0, 1) == 0 || pat_len_hint(pending_items.size()))
                    push_item(kmp_pkg::OP_CLEAR, 8'($urandom));
                plen = $urandom_range(1, 6);
                repeat (plen)
                    push_item(kmp_pkg::OP_APPEND, ($urandom_range(0, 2) == 0) ? sym_b : sym_a);
                if ($urandom_range(0, 4) != 0)
                    push_item(kmp_pkg::OP_RESTART, 8'($urandom));
                tlen = $urandom_range(10, 40);
                repeat (tlen) begin
                    if ($urandom_range(0, 29) == 0)
                        push_item(kmp_pkg::OP_APPEND, pick_symbol(sym_a, sym_b, sym_x));
                    else if ($urandom_range(0, 39) == 0)
                        push_item(kmp_pkg::OP_RESTART, 8'($urandom));
                    push_item(kmp_pkg::OP_TEXT, pick_symbol(sym_a, sym_b, sym_x));
                end
            end
        end
        total_items = pending_items.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (in_accepted < total_items || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("%0d items sent, %0d text bytes scanned, %0d matches predicted",
                 total_items, n_text, n_hits);
        $display("%0d appends hit a full store, %0d results compared",
                 n_full, out_checked);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d bad results", mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/kmp_pkg.sv
hw/rtl/kmp_ram.sv
hw/rtl/kmp_fsm.sv
hw/rtl/kmp_stream_matcher.sv
hw/rtl/kmp_checker.sv
test/kmp_stream_matcher_test.sv
